// File: hw/rtl/ostt_pkg.sv
// ============================================================================
// ostt_pkg
// Shared command codes, result kinds and memory control type for the
// one-shot timer table.
// ============================================================================
package ostt_pkg;

    localparam int SLOT_W   = 4;
    localparam int PERIOD_W = 16;
    localparam int ADV_W    = 16;
    localparam int CMD_W    = 3;
    localparam int KIND_W   = 2;

    // Command codes carried by a request.
    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_OPEN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLOSE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOFREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd3;

    // Per-cycle control of the slot memories.
    typedef struct packed {
        logic rd_en;
        logic wr_start;
        logic wr_period;
    } t_mem_op;

endpackage

// File: hw/rtl/ostt_slot_mem.sv
// ============================================================================
// ostt_slot_mem
// Start time and period memories of the timer slots, with the expiry test
// on the registered read data.
// ============================================================================
module ostt_slot_mem import ostt_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32,
    parameter int IW        = 4
) (
    input  logic                 i_clk,
    input  t_mem_op              i_op,
    input  logic [IW-1:0]        i_rd_addr,
    input  logic [IW-1:0]        i_wr_addr,
    input  logic [TIME_BITS-1:0] i_wr_start,
    input  logic [PERIOD_W-1:0]  i_wr_period,
    input  logic [TIME_BITS-1:0] i_time_now,
    output logic                 o_expired
);

    logic [TIME_BITS-1:0] r_start_mem  [SLOTS];
    logic [PERIOD_W-1:0]  r_period_mem [SLOTS];
    logic [TIME_BITS-1:0] r_rd_start;
    logic [PERIOD_W-1:0]  r_rd_period;
    logic [TIME_BITS-1:0] elapsed;

    always_ff @(posedge i_clk) begin
        if (i_op.wr_start) begin
            r_start_mem[i_wr_addr] <= i_wr_start;
        end
        if (i_op.wr_period) begin
            r_period_mem[i_wr_addr] <= i_wr_period;
        end
        if (i_op.rd_en) begin
            r_rd_start  <= r_start_mem[i_rd_addr];
            r_rd_period <= r_period_mem[i_rd_addr];
        end
    end

    // Elapsed time wraps with the counter, so a plain subtraction is enough.
    assign elapsed   = i_time_now - r_rd_start;
    assign o_expired = elapsed >= {{(TIME_BITS-PERIOD_W){1'b0}}, r_rd_period};

endmodule

// File: hw/rtl/one_shot_timer_table_core.sv
// ============================================================================
// one_shot_timer_table_core
// Pool of one-shot timers with create, free, open, close and tick-and-scan
// commands, reporting allocated and expired slot numbers.
// ============================================================================
//
//  Channel   Direction  Handshake                    Payload
//  -------   ---------  ---------------------------  ------------------------
//  request   in         i_in_valid / o_in_ready      cmd, slot, period, advance
//  result    out        o_out_valid / i_out_ready    kind, slot_out, last
//
//  Free, open, close and unknown commands go through S_CMD. Create walks the
//  in-use flags from slot 0. Tick scans every slot: the slot memories are
//  read one slot per cycle through their single read port, except while an
//  expiry waits on a full output, and the check of a slot overlaps the read
//  of the next one. Any command can stall on a full result channel.
//  Reset clears the flags, the time counter and all control state at once.
//  The next request is taken as soon as the previous one has placed its last
//  result in the output register, even if that result is still waiting.
//
module one_shot_timer_table_core import ostt_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request channel.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic [ADV_W-1:0]    i_advance,
    // Result channel.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KIND_W-1:0]   o_kind,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic                o_last
);

    // Index width for the slot arrays, and a counter width that also holds
    // SLOTS itself so that it can mark the end of a walk.
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] IDX_END = CW'(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMD,
        S_ALLOC,
        S_SCAN
    } t_state;

    t_state r_state, n_state;

    // Request held for the duration of its work.
    logic [CMD_W-1:0]     r_cmd, n_cmd;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [PERIOD_W-1:0]  r_period, n_period;

    // Slot flags live in flip-flops so that reset clears them at once.
    logic [SLOTS-1:0]     r_in_use, n_in_use;
    logic [SLOTS-1:0]     r_armed, n_armed;
    logic [TIME_BITS-1:0] r_time, n_time;

    // Walk counter, and the slot whose memory read is now in the read register.
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_pv, n_pv;
    logic [IW-1:0]        r_pidx, n_pidx;

    // Output register.
    logic                 r_ov, n_ov;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic [SLOT_W-1:0]    r_slot_out, n_slot_out;
    logic                 r_last, n_last;

    // Memory interface.
    t_mem_op              mem_op;
    logic [IW-1:0]        mem_rd_addr;
    logic [IW-1:0]        mem_wr_addr;
    logic                 mem_expired;

    logic                 out_free;
    logic                 slot_ok;
    logic [IW-1:0]        idx_lo;
    logic [IW-1:0]        slot_lo;
    logic                 hit;

    ostt_slot_mem #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS),
        .IW        (IW)
    ) u_slot_mem (
        .i_clk       (i_clk),
        .i_op        (mem_op),
        .i_rd_addr   (mem_rd_addr),
        .i_wr_addr   (mem_wr_addr),
        .i_wr_start  (r_time),
        .i_wr_period (r_period),
        .i_time_now  (r_time),
        .o_expired   (mem_expired)
    );

    assign out_free = !r_ov || i_out_ready;
    assign slot_ok  = int'(r_slot) < SLOTS;
    assign idx_lo   = r_idx[IW-1:0];
    assign slot_lo  = IW'(r_slot);

    // A slot reported as expired must be in use, armed and at or past its period.
    // No memory write happens during a scan, so the read data is current.
    assign hit = r_pv && r_in_use[r_pidx] && r_armed[r_pidx] && mem_expired;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_slot     = r_slot;
        n_period   = r_period;
        n_in_use   = r_in_use;
        n_armed    = r_armed;
        n_time     = r_time;
        n_idx      = r_idx;
        n_pv       = r_pv;
        n_pidx     = r_pidx;
        n_ov       = r_ov;
        n_kind     = r_kind;
        n_slot_out = r_slot_out;
        n_last     = r_last;
        mem_op      = '0;
        mem_rd_addr = idx_lo;
        mem_wr_addr = idx_lo;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_cmd;
                    n_slot   = i_slot;
                    n_period = i_period;
                    n_idx    = '0;
                    n_pv     = 1'b0;
                    if (i_cmd == CMD_CREATE) begin
                        n_state = S_ALLOC;
                    end else if (i_cmd == CMD_TICK) begin
                        // The counter moves first; the scan sees the new time.
                        n_time  = r_time + TIME_BITS'(i_advance);
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_CMD;
                    end
                end
            end

            S_CMD: begin
                if (out_free) begin
                    mem_wr_addr = slot_lo;
                    if (slot_ok) begin
                        if (r_cmd == CMD_FREE) begin
                            n_in_use[slot_lo] = 1'b0;
                        end else if (r_cmd == CMD_OPEN) begin
                            mem_op.wr_start  = 1'b1;
                            n_armed[slot_lo] = 1'b1;
                        end else if (r_cmd == CMD_CLOSE) begin
                            n_armed[slot_lo] = 1'b0;
                        end
                    end
                    n_ov       = 1'b1;
                    n_kind     = KIND_DONE;
                    n_slot_out = '0;
                    n_last     = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            S_ALLOC: begin
                if (r_idx == IDX_END) begin
                    // Every slot is taken.
                    if (out_free) begin
                        n_ov       = 1'b1;
                        n_kind     = KIND_NOFREE;
                        n_slot_out = '0;
                        n_last     = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (!r_in_use[idx_lo]) begin
                    if (out_free) begin
                        mem_op.wr_start  = 1'b1;
                        mem_op.wr_period = 1'b1;
                        n_in_use[idx_lo] = 1'b1;
                        n_armed[idx_lo]  = 1'b1;
                        n_ov             = 1'b1;
                        n_kind           = KIND_ALLOC;
                        n_slot_out       = SLOT_W'(idx_lo);
                        n_last           = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_SCAN: begin
                if (!r_pv && r_idx == IDX_END) begin
                    // All slots checked; close the scan with the done result.
                    if (out_free) begin
                        n_ov       = 1'b1;
                        n_kind     = KIND_DONE;
                        n_slot_out = '0;
                        n_last     = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (!hit || out_free) begin
                    // When an expiry waits on a full output, the read register
                    // and the walk both hold until the result can move.
                    if (hit) begin
                        n_armed[r_pidx] = 1'b0;
                        n_ov            = 1'b1;
                        n_kind          = KIND_EXPIRED;
                        n_slot_out      = SLOT_W'(r_pidx);
                        n_last          = 1'b0;
                    end
                    if (r_idx != IDX_END) begin
                        mem_op.rd_en = 1'b1;
                        n_pv         = 1'b1;
                        n_pidx       = idx_lo;
                        n_idx        = r_idx + 1'b1;
                    end else begin
                        n_pv = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_use <= '0;
            r_armed  <= '0;
            r_time   <= '0;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_use <= n_in_use;
            r_armed  <= n_armed;
            r_time   <= n_time;
            r_idx    <= n_idx;
            r_pv     <= n_pv;
            r_ov     <= n_ov;
        end
        r_cmd      <= n_cmd;
        r_slot     <= n_slot;
        r_period   <= n_period;
        r_pidx     <= n_pidx;
        r_kind     <= n_kind;
        r_slot_out <= n_slot_out;
        r_last     <= n_last;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_kind      = r_kind;
    assign o_slot_out  = r_slot_out;
    assign o_last      = r_last;

endmodule
